>>> hdl/bottle_count_dispense_controller_macros.svh
// assertion macros shared by the bottle count dispense controller
`ifndef BOTTLE_COUNT_DISPENSE_CONTROLLER_MACROS_SVH
`define BOTTLE_COUNT_DISPENSE_CONTROLLER_MACROS_SVH

// same-cycle implication on aclk, off during reset
`define BCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, off during reset
`define BCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bcd_pkg.sv
// package with widths, register codes, reset values and shared structs
package bcd_pkg;

    localparam int DIST_W  = 12;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int MPB_W   = 16;
    localparam int CFG_W   = 32;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_RECOUNT   = 2'd1,
        REG_TIMEOUT   = 2'd2,
        REG_MPB       = 2'd3
    } cfg_index_t;

    localparam logic [DIST_W-1:0] THRESHOLD_RST = DIST_W'(100);
    localparam logic [TIME_W-1:0] RECOUNT_RST   = TIME_W'(1000);
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = TIME_W'(2000);
    localparam logic [MPB_W-1:0]  MPB_RST       = MPB_W'(5000);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [DIST_W-1:0] threshold_mm;
        logic [TIME_W-1:0] recount_gap_ms;
        logic [TIME_W-1:0] session_timeout_ms;
        logic [MPB_W-1:0]  ms_per_bottle;
    } cfg_t;

    typedef struct packed {
        logic               valve_open;
        logic               object_present;
        logic [COUNT_W-1:0] bottle_count;
        logic               bottle_added;
        logic               session_ended;
        logic               dispense_done;
    } result_t;

    typedef struct packed {
        logic               dispensing;
        logic [COUNT_W-1:0] count;
    } status_t;

endpackage

>>> hdl/bcd_cfg.sv
// configuration register file
module bcd_cfg (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  bcd_pkg::cfg_index_t      cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0] cfg_data,
    output bcd_pkg::cfg_t            cfg
);
    import bcd_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_THRESHOLD: cfg_next.threshold_mm       = cfg_data[DIST_W-1:0];
                REG_RECOUNT:   cfg_next.recount_gap_ms     = cfg_data[TIME_W-1:0];
                REG_TIMEOUT:   cfg_next.session_timeout_ms = cfg_data[TIME_W-1:0];
                REG_MPB:       cfg_next.ms_per_bottle      = cfg_data[MPB_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_mm       <= THRESHOLD_RST;
            cfg_reg.recount_gap_ms     <= RECOUNT_RST;
            cfg_reg.session_timeout_ms <= TIMEOUT_RST;
            cfg_reg.ms_per_bottle      <= MPB_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/bcd_engine.sv
// controller state and per-poll update logic
module bcd_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step_en,
    input  bcd_pkg::cfg_t              cfg,
    input  logic [bcd_pkg::DIST_W-1:0] distance_mm,
    input  logic [bcd_pkg::TIME_W-1:0] now_ms,
    output bcd_pkg::result_t           result,
    output bcd_pkg::status_t           status
);
    import bcd_pkg::*;

    logic               present_reg, present_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               session_reg, session_next;
    logic [TIME_W-1:0]  last_stamp_reg, last_stamp_next;
    logic               dispensing_reg, dispensing_next;
    logic [TIME_W-1:0]  start_stamp_reg, start_stamp_next;
    logic [TIME_W-1:0]  length_reg, length_next;

    logic [TIME_W-1:0]  since_start;
    logic [TIME_W-1:0]  since_last;
    logic [TIME_W-1:0]  product;
    logic               added, ended, done;

    assign since_start = now_ms - start_stamp_reg;
    assign since_last  = now_ms - last_stamp_reg;
    assign product     = TIME_W'(count_reg) * TIME_W'(cfg.ms_per_bottle);

    always_comb begin
        present_next     = present_reg;
        count_next       = count_reg;
        session_next     = session_reg;
        last_stamp_next  = last_stamp_reg;
        dispensing_next  = dispensing_reg;
        start_stamp_next = start_stamp_reg;
        length_next      = length_reg;
        added            = 1'b0;
        ended            = 1'b0;
        done             = 1'b0;

        if (dispensing_reg) begin
            if (since_start >= length_reg) begin
                dispensing_next = 1'b0;
                done            = 1'b1;
            end
        end else begin
            if (!present_reg && (distance_mm < cfg.threshold_mm)) begin
                present_next = 1'b1;
            end else if (present_reg && (distance_mm > cfg.threshold_mm)
                         && (since_last > cfg.recount_gap_ms)) begin
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + COUNT_W'(1);
                end
                present_next    = 1'b0;
                last_stamp_next = now_ms;
                session_next    = 1'b1;
                added           = 1'b1;
            end
            // a bottle counted now restarts the idle time, so no end this poll
            if (session_reg && !added && (since_last > cfg.session_timeout_ms)) begin
                session_next = 1'b0;
                if (count_reg != '0) begin
                    length_next      = product;
                    count_next       = '0;
                    dispensing_next  = 1'b1;
                    start_stamp_next = now_ms;
                    ended            = 1'b1;
                end
            end
        end

        result.valve_open     = dispensing_next;
        result.object_present = present_next;
        result.bottle_count   = count_next;
        result.bottle_added   = added;
        result.session_ended  = ended;
        result.dispense_done  = done;
    end

    assign status.dispensing = dispensing_reg;
    assign status.count      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg     <= 1'b0;
            count_reg       <= '0;
            session_reg     <= 1'b0;
            last_stamp_reg  <= '0;
            dispensing_reg  <= 1'b0;
            start_stamp_reg <= '0;
            length_reg      <= '0;
        end else if (step_en) begin
            present_reg     <= present_next;
            count_reg       <= count_next;
            session_reg     <= session_next;
            last_stamp_reg  <= last_stamp_next;
            dispensing_reg  <= dispensing_next;
            start_stamp_reg <= start_stamp_next;
            length_reg      <= length_next;
        end
    end

endmodule

>>> hdl/bottle_count_dispense_controller.sv
// top level of the bottle count dispense controller
// Each s_ beat is one sensor poll (distance in mm and a wrapping ms time stamp)
// and yields exactly one m_ beat, in order. A poll is held in the input
// register, is evaluated against the controller state in a single pass (two
// wrapping 32-bit subtracts with compares and one 16x16 multiply for the
// dispense length), and lands in the result register, which drives m_valid.
// A new poll is taken every cycle, also while a result waits on m_ready,
// until both registers are full. Configuration writes are taken every cycle
// (cfg_ready is always high) and are meant for idle periods only.
`include "bottle_count_dispense_controller_macros.svh"

module bottle_count_dispense_controller (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  bcd_pkg::cfg_index_t         cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]   cfg_data,
    // poll input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bcd_pkg::DIST_W-1:0]  s_distance_mm,
    input  logic [bcd_pkg::TIME_W-1:0]  s_now_ms,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_valve_open,
    output logic                        m_object_present,
    output logic [bcd_pkg::COUNT_W-1:0] m_bottle_count,
    output logic                        m_bottle_added,
    output logic                        m_session_ended,
    output logic                        m_dispense_done
);
    import bcd_pkg::*;

    cfg_t    cfg;
    result_t result;
    status_t status;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [DIST_W-1:0] dist_reg;
    logic [TIME_W-1:0] now_reg;

    // result register
    logic    m_valid_reg, m_valid_next;
    result_t res_reg;

    logic s_take;   // input beat accepted
    logic advance;  // poll moves from input register into result register

    // the poll advances when the result register is empty or drains this cycle
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    // input register frees up when empty or when its poll advances
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign in_valid_next = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_valid_next  = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    bcd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state only moves when the poll is committed to the result register
    bcd_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .cfg         (cfg),
        .distance_mm (dist_reg),
        .now_ms      (now_reg),
        .result      (result),
        .status      (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            dist_reg <= s_distance_mm;
            now_reg  <= s_now_ms;
        end
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_valve_open     = res_reg.valve_open;
    assign m_object_present = res_reg.object_present;
    assign m_bottle_count   = res_reg.bottle_count;
    assign m_bottle_added   = res_reg.bottle_added;
    assign m_session_ended  = res_reg.session_ended;
    assign m_dispense_done  = res_reg.dispense_done;

    // session end must leave the valve open and the count cleared
    `BCD_ASSERT_NEXT(a_end_starts_dispense, advance && result.session_ended, status.dispensing && (status.count == '0), "session end did not start dispensing")
    // finished dispensing must close the valve
    `BCD_ASSERT_NEXT(a_done_closes_valve, advance && result.dispense_done, !status.dispensing, "dispense done left valve open")
    // polls during dispensing leave the count alone
    `BCD_ASSERT_NEXT(a_dispense_holds_count, advance && status.dispensing, $stable(status.count), "count changed while dispensing")
    // both registers full and output stalled: no new poll may be taken
    `BCD_ASSERT_SAME(a_full_blocks_input, in_valid_reg && m_valid_reg && !m_ready, !s_ready, "input taken while pipeline full")

endmodule

>>> tb/sv/bcd_result_checker.sv
`timescale 1ns / 100ps
// result checker for the bottle count dispense controller: predicts each result beat and compares
module bcd_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  bcd_pkg::cfg_index_t         cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [bcd_pkg::DIST_W-1:0]  s_distance_mm,
    input  logic [bcd_pkg::TIME_W-1:0]  s_now_ms,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_valve_open,
    input  logic                        m_object_present,
    input  logic [bcd_pkg::COUNT_W-1:0] m_bottle_count,
    input  logic                        m_bottle_added,
    input  logic                        m_session_ended,
    input  logic                        m_dispense_done,
    output int                          error_count,
    output int                          outcomes_pending,
    output int                          beats_checked,
    output int                          bottles_seen,
    output int                          sessions_seen,
    output int                          dispenses_seen,
    output int                          peak_count
);
    import bcd_pkg::*;

    cfg_t              regs;
    logic              present;
    logic [COUNT_W-1:0] count;
    logic              in_session;
    logic [TIME_W-1:0] last_bottle_ms;
    logic              dispensing;
    logic [TIME_W-1:0] dispense_start_ms;
    logic [TIME_W-1:0] dispense_len_ms;
    result_t           expected_outcomes[$];

    function automatic logic [TIME_W-1:0] ms_since(logic [TIME_W-1:0] now,
                                                   logic [TIME_W-1:0] stamp);
        return now - stamp;
    endfunction

    // one poll against the controller state, state updated in place
    function automatic result_t poll_outcome(logic [DIST_W-1:0] dist_mm,
                                             logic [TIME_W-1:0] now);
        result_t r;
        r = '0;
        if (dispensing) begin
            if (ms_since(now, dispense_start_ms) >= dispense_len_ms) begin
                dispensing = 1'b0;
                r.dispense_done = 1'b1;
            end
        end else begin
            if (!present && dist_mm < regs.threshold_mm) begin
                present = 1'b1;
            end else if (present && dist_mm > regs.threshold_mm &&
                         ms_since(now, last_bottle_ms) > regs.recount_gap_ms) begin
                if (count != COUNT_MAX)
                    count = count + 1'b1;
                present = 1'b0;
                last_bottle_ms = now;
                in_session = 1'b1;
                r.bottle_added = 1'b1;
            end
            if (in_session && ms_since(now, last_bottle_ms) > regs.session_timeout_ms) begin
                in_session = 1'b0;
                if (count != '0) begin
                    dispense_len_ms = TIME_W'(count) * TIME_W'(regs.ms_per_bottle);
                    count = '0;
                    dispensing = 1'b1;
                    dispense_start_ms = now;
                    r.session_ended = 1'b1;
                end
            end
        end
        r.valve_open = dispensing;
        r.object_present = present;
        r.bottle_count = count;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        // keep the log short on a badly broken block
        if (error_count <= 50)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            regs.threshold_mm       = THRESHOLD_RST;
            regs.recount_gap_ms     = RECOUNT_RST;
            regs.session_timeout_ms = TIMEOUT_RST;
            regs.ms_per_bottle      = MPB_RST;
            present           = 1'b0;
            count             = '0;
            in_session        = 1'b0;
            last_bottle_ms    = '0;
            dispensing        = 1'b0;
            dispense_start_ms = '0;
            dispense_len_ms   = '0;
            expected_outcomes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: regs.threshold_mm       = cfg_data[DIST_W-1:0];
                    REG_RECOUNT:   regs.recount_gap_ms     = cfg_data[TIME_W-1:0];
                    REG_TIMEOUT:   regs.session_timeout_ms = cfg_data[TIME_W-1:0];
                    REG_MPB:       regs.ms_per_bottle      = cfg_data[MPB_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_outcomes.push_back(poll_outcome(s_distance_mm, s_now_ms));
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_bottle_count, '0);
                end else begin
                    want = expected_outcomes.pop_front();
                    beats_checked++;
                    bottles_seen   += want.bottle_added;
                    sessions_seen  += want.session_ended;
                    dispenses_seen += want.dispense_done;
                    if (want.bottle_count > peak_count)
                        peak_count = want.bottle_count;
                    check_field("valve_open",     m_valve_open,     want.valve_open);
                    check_field("object_present", m_object_present, want.object_present);
                    check_field("bottle_count",   m_bottle_count,   want.bottle_count);
                    check_field("bottle_added",   m_bottle_added,   want.bottle_added);
                    check_field("session_ended",  m_session_ended,  want.session_ended);
                    check_field("dispense_done",  m_dispense_done,  want.dispense_done);
                end
            end
        end
        outcomes_pending <= expected_outcomes.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench top for the bottle count dispense controller: stimulus, reset and verdict
module testbench;
    import bcd_pkg::*;

    // generous bound on the whole run length
    localparam int LIMIT_CYCLES = 200_000;
    // bottles counted in the burst that earns a long dispense
    localparam int BURST_BOTTLES = 25;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index     = REG_THRESHOLD;
    logic [CFG_W-1:0]   cfg_data      = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [DIST_W-1:0]  s_distance_mm = '0;
    logic [TIME_W-1:0]  s_now_ms      = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic               m_valve_open;
    logic               m_object_present;
    logic [COUNT_W-1:0] m_bottle_count;
    logic               m_bottle_added;
    logic               m_session_ended;
    logic               m_dispense_done;

    // handed up from the checker
    int error_count;
    int outcomes_pending;
    int beats_checked;
    int bottles_seen;
    int sessions_seen;
    int dispenses_seen;
    int peak_count;

    // idling knobs, in percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;

    int cycle_count = 0;
    int config_sets = 0;

    // stimulus side copy of the threshold so distances can be aimed at it
    logic [DIST_W-1:0] cur_threshold = THRESHOLD_RST;
    // running millisecond time of the scene being played
    logic [TIME_W-1:0] clk_ms = '0;

    bottle_count_dispense_controller u_dut (.*);

    bcd_result_checker u_checker (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: ready decided fresh every cycle, so stalls land on every phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, outcomes_pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one register write beat; only ever called with the block idle
    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one poll beat, with random idle cycles in front of it
    task automatic send_poll(logic [DIST_W-1:0] dist_mm, logic [TIME_W-1:0] now);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_distance_mm <= dist_mm;
        s_now_ms      <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop polling and wait until every expected result has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outcomes_pending != 0);
        // pipeline is two deep; let it settle before touching registers
        repeat (3) @(posedge aclk);
    endtask

    // full register set; unused upper data bits carry noise the block must drop
    task automatic set_regs(logic [DIST_W-1:0] thr, logic [TIME_W-1:0] gap,
                            logic [TIME_W-1:0] timeout, logic [MPB_W-1:0] mpb);
        logic [CFG_W-1:0] word;
        drain();
        word = $urandom;
        word[DIST_W-1:0] = thr;
        write_reg(REG_THRESHOLD, word);
        write_reg(REG_RECOUNT, gap);
        write_reg(REG_TIMEOUT, timeout);
        word = $urandom;
        word[MPB_W-1:0] = mpb;
        write_reg(REG_MPB, word);
        cur_threshold = thr;
        config_sets++;
    endtask

    // a distance strictly below (near) or strictly above the threshold,
    // falling back to the threshold itself where no such value exists
    function automatic logic [DIST_W-1:0] distance_for(bit near);
        if (near)
            return (cur_threshold == '0) ? '0 : DIST_W'($urandom_range(cur_threshold - 1, 0));
        return (cur_threshold == '1) ? '1 : DIST_W'($urandom_range(4095, cur_threshold + 1));
    endfunction

    // random scene: objects come and go in short runs while time moves forward
    // by random steps; some polls jump far ahead in time, some are pure noise
    // (any distance, any time stamp, possibly going backwards)
    task automatic run_phase(int items, int unsigned step_max, int idle_pct, int stall);
        bit          near;
        int          left;
        int unsigned roll;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        near = 1'b0;
        left = 0;
        // some scenes start just short of the time stamp wrap
        if ($urandom_range(2, 0) == 0)
            clk_ms = 32'hFFFF_FFFF - $urandom_range(20000, 0);
        else
            clk_ms = $urandom;
        repeat (items) begin
            if (left == 0) begin
                near = !near;
                left = $urandom_range(4, 1);
            end
            left--;
            roll = $urandom_range(99, 0);
            if (roll < 6) begin
                send_poll(DIST_W'($urandom), $urandom);
            end else begin
                clk_ms += (roll < 10) ? $urandom : $urandom_range(step_max, 0);
                send_poll(($urandom_range(19, 0) == 0) ? cur_threshold : distance_for(near),
                          clk_ms);
            end
        end
    endtask

    initial begin : stimulus
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] burst_len;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed walk at reset settings: threshold 100, gap 1000,
        // timeout 2000, 5000 ms per bottle
        send_poll(0, 0);                 // arrival at the smallest distance
        send_poll(100, 500);             // distance equal to threshold does nothing
        send_poll(4095, 1000);           // leaving exactly at the recount gap, not counted
        send_poll(4095, 1001);           // first bottle
        send_poll(99, 1100);             // arrival just below threshold
        send_poll(101, 2001);            // gap just reached, still not counted
        send_poll(101, 2002);            // second bottle
        send_poll(4095, 4002);           // session timeout exactly reached, no end yet
        send_poll(0, 4003);              // arrival and session end in one poll
        send_poll(4095, 9000);           // distance ignored while the valve is open
        send_poll(0, 14002);             // one ms short of the dispense length
        send_poll(0, 14003);             // dispense done
        // time stamp wrap between bottles within one session, then a dispense
        send_poll(4095, 32'hFFFF_FF00);
        send_poll(0, 32'h0000_0100);
        send_poll(4095, 32'h0000_0500);
        t = 32'h0000_0500 + 2001;
        send_poll(4095, t);              // session ends, two bottles earned
        send_poll(0, t + 10000);
        // zero ms per bottle: dispensing ends on the very next poll
        set_regs(100, 0, 0, 0);
        t = 32'h0001_0000;
        send_poll(0, t);
        send_poll(4095, t + 1);
        send_poll(4095, t + 2);
        send_poll(4095, t + 2);

        // burst of bottles with no recount gap and a session that never times
        // out, then a long dispense at the largest ms per bottle, ending one
        // ms after it was still running
        set_regs(2048, 0, '1, '1);
        t = $urandom;
        repeat (BURST_BOTTLES) begin
            send_poll(distance_for(1'b1), t);
            t++;
            send_poll(distance_for(1'b0), t);
            t++;
        end
        set_regs(2048, 0, 0, '1);
        burst_len = TIME_W'(BURST_BOTTLES) * TIME_W'(16'hFFFF);
        send_poll(2048, t);
        send_poll(DIST_W'($urandom), t + burst_len - 1);
        send_poll(DIST_W'($urandom), t + burst_len);

        // random scenes, cycling through the idling modes:
        // none, sender idle, receiver stalling, both
        set_regs($urandom_range(4095, 0), $urandom_range(300, 0),
                 $urandom_range(800, 0), $urandom_range(100, 0));
        run_phase(200, 400, 0, 0);
        set_regs($urandom_range(4095, 0), $urandom_range(300, 0),
                 $urandom_range(800, 0), $urandom_range(100, 0));
        run_phase(150, 400, 71, 0);
        set_regs($urandom_range(4095, 0), $urandom_range(300, 0),
                 $urandom_range(800, 0), $urandom_range(100, 0));
        run_phase(150, 400, 0, 71);
        set_regs($urandom_range(4095, 0), $urandom_range(300, 0),
                 $urandom_range(800, 0), $urandom_range(100, 0));
        run_phase(150, 400, 22, 22);
        // back to the reset values, with slower time steps to match
        set_regs(THRESHOLD_RST, RECOUNT_RST, TIMEOUT_RST, MPB_RST);
        run_phase(120, 1500, 22, 22);
        // nothing can arrive; sessions never time out
        set_regs(0, 0, '1, '1);
        run_phase(50, 400, 71, 0);
        // nothing can leave or be recounted; open sessions end at once
        set_regs('1, '1, 0, 0);
        run_phase(50, 400, 0, 71);
        // recount gap, timeout and ms per bottle at zero, very short time steps
        set_regs($urandom_range(4095, 0), 0, 0, 0);
        run_phase(100, 5, 0, 0);
        // long dispenses that mostly end on time jumps
        set_regs($urandom_range(4095, 0), $urandom_range(2000, 0),
                 $urandom_range(4000, 0), $urandom_range(65535, 0));
        run_phase(100, 3000, 22, 22);

        drain();

        $display("covered %0d polls over %0d register settings, %0d bottles counted, peak count %0d",
                 beats_checked, config_sets + 1, bottles_seen, peak_count);
        $display("%0d sessions went to dispensing, %0d dispenses finished, %0d mismatches",
                 sessions_seen, dispenses_seen, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bcd_pkg.sv
hdl/bcd_cfg.sv
hdl/bcd_engine.sv
hdl/bottle_count_dispense_controller.sv
tb/sv/bcd_result_checker.sv
tb/sv/testbench.sv
